// ----- src/assert_macros.svh -----
// Assertion helpers used by the RTL (sds_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- src/sds_pkg.sv -----
package sds_pkg;

  localparam int MAX_DIRS = 16;
  localparam int DIR_W    = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
  localparam int CNT_W    = $clog2(MAX_DIRS + 1);

  localparam int LOAD_W   = 10;
  localparam int KB_W     = 32;
  localparam int BYTES_W  = 48;
  localparam int HDR_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [LOAD_W-1:0] LOAD_LIMIT_RST = LOAD_W'(1000);

  localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_LIMIT  = CFG_IDX_W'(1);

  localparam logic MODE_LEAST_LOAD  = 1'b0;
  localparam logic MODE_ROUND_ROBIN = 1'b1;

  typedef struct packed {
    logic                last;
    logic                ll_ok;
    logic                rr_ok;
    logic [LOAD_W-1:0]   load;
    logic                unl;
    logic [BYTES_W-1:0]  lim;
    logic [KB_W-1:0]     free_kb;
  } sds_rec_t;

endpackage

// ----- src/sds_in_if.sv -----
interface sds_in_if;
  import sds_pkg::*;

  logic               valid;
  logic               ready;
  logic               last_dir;
  logic               write_locked;
  logic [KB_W-1:0]    used_kb;
  logic [KB_W-1:0]    capacity_kb;
  logic               limit_unlimited;
  logic [BYTES_W-1:0] size_limit;
  logic [LOAD_W-1:0]  load_report;
  logic               load_error;
  logic [BYTES_W-1:0] object_bytes;
  logic               size_unknown;
  logic [HDR_W-1:0]   header_bytes;

  modport source (output valid, last_dir, write_locked, used_kb, capacity_kb, limit_unlimited,
                  size_limit, load_report, load_error, object_bytes, size_unknown,
                  header_bytes, input ready);
  modport sink (input valid, last_dir, write_locked, used_kb, capacity_kb, limit_unlimited,
                size_limit, load_report, load_error, object_bytes, size_unknown,
                header_bytes, output ready);
endinterface

// ----- src/sds_out_if.sv -----
interface sds_out_if;
  import sds_pkg::*;

  logic             valid;
  logic             ready;
  logic [DIR_W-1:0] chosen_dir;
  logic             none_found;

  modport source (output valid, chosen_dir, none_found, input ready);
  modport sink (input valid, chosen_dir, none_found, output ready);
endinterface

// ----- src/sds_cfg_if.sv -----
interface sds_cfg_if;
  import sds_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/sds_queue.sv -----
module sds_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sds_pkg::sds_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output sds_pkg::sds_rec_t head_rec
);
  import sds_pkg::*;

  sds_rec_t             slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_rec   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ----- src/sds_front.sv -----
module sds_front (
  input  logic                        q_full,
  input  logic [sds_pkg::LOAD_W-1:0]  load_limit,
  output logic                        q_push,
  output sds_pkg::sds_rec_t           q_rec,
  sds_in_if.sink                      in_req
);
  import sds_pkg::*;

  logic               common_ok;
  logic [BYTES_W:0]   ll_size;
  logic               rr_fit, ll_fit;

  // object plus header, compared at full width
  assign ll_size   = {1'b0, in_req.object_bytes} + {{(BYTES_W + 1 - HDR_W){1'b0}},
                     in_req.header_bytes};
  assign common_ok = !in_req.load_error && (in_req.load_report <= load_limit) &&
                     !in_req.write_locked && (in_req.used_kb <= in_req.capacity_kb);
  assign rr_fit    = in_req.limit_unlimited ||
                     (!in_req.size_unknown && (in_req.size_limit > in_req.object_bytes));
  assign ll_fit    = in_req.limit_unlimited ||
                     (!in_req.size_unknown && ({1'b0, in_req.size_limit} > ll_size));

  assign in_req.ready = !q_full;
  assign q_push       = in_req.valid;

  always_comb begin
    q_rec.last    = in_req.last_dir;
    q_rec.ll_ok   = common_ok && ll_fit;
    q_rec.rr_ok   = common_ok && rr_fit;
    q_rec.load    = in_req.load_report;
    q_rec.unl     = in_req.limit_unlimited;
    q_rec.lim     = in_req.size_limit;
    q_rec.free_kb = in_req.capacity_kb - in_req.used_kb;
  end

endmodule

// ----- src/sds_back.sv -----
`include "assert_macros.svh"

module sds_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              select_mode,
  input  logic              q_valid,
  input  sds_pkg::sds_rec_t q_rec,
  output logic              q_pop,
  sds_out_if.source         out_req
);
  import sds_pkg::*;

  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [DIR_W-1:0]   rr_prev_r, rr_prev_nxt;
  logic               best_valid_r, best_valid_nxt;
  logic [DIR_W-1:0]   best_index_r, best_index_nxt;
  logic [LOAD_W-1:0]  best_load_r, best_load_nxt;
  logic               best_unl_r, best_unl_nxt;
  logic [BYTES_W-1:0] best_lim_r, best_lim_nxt;
  logic [KB_W-1:0]    best_free_r, best_free_nxt;
  logic               after_valid_r, after_valid_nxt;
  logic [DIR_W-1:0]   after_index_r, after_index_nxt;
  logic               wrap_valid_r, wrap_valid_nxt;
  logic [DIR_W-1:0]   wrap_index_r, wrap_index_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DIR_W-1:0]   out_dir_r, out_dir_nxt;
  logic               out_none_r, out_none_nxt;

  logic               in_range, take, found;
  logic [DIR_W-1:0]   idx, chosen;
  logic [CNT_W-1:0]   rr_inc;

  assign q_pop    = q_valid && (!q_rec.last || !out_valid_r || out_req.ready);
  assign in_range = (pos_r < CNT_W'(MAX_DIRS));
  assign idx      = pos_r[DIR_W-1:0];

  always_comb begin
    if (!best_valid_r || (q_rec.load < best_load_r)) begin
      take = 1'b1;
    end else if (q_rec.load > best_load_r) begin
      take = 1'b0;
    end else if (!best_unl_r && (q_rec.unl || (q_rec.lim > best_lim_r))) begin
      take = 1'b0;
    end else begin
      take = (q_rec.free_kb >= best_free_r);
    end
  end

  always_comb begin
    pos_nxt         = pos_r;
    rr_prev_nxt     = rr_prev_r;
    best_valid_nxt  = best_valid_r;
    best_index_nxt  = best_index_r;
    best_load_nxt   = best_load_r;
    best_unl_nxt    = best_unl_r;
    best_lim_nxt    = best_lim_r;
    best_free_nxt   = best_free_r;
    after_valid_nxt = after_valid_r;
    after_index_nxt = after_index_r;
    wrap_valid_nxt  = wrap_valid_r;
    wrap_index_nxt  = wrap_index_r;
    out_valid_nxt   = out_valid_r && !out_req.ready;
    out_dir_nxt     = out_dir_r;
    out_none_nxt    = out_none_r;
    found           = 1'b0;
    chosen          = '0;
    rr_inc          = {1'b0, rr_prev_r} + 1'b1;

    if (q_pop && in_range) begin
      if (q_rec.ll_ok && take) begin
        best_valid_nxt = 1'b1;
        best_index_nxt = idx;
        best_load_nxt  = q_rec.load;
        best_unl_nxt   = q_rec.unl;
        best_lim_nxt   = q_rec.lim;
        best_free_nxt  = q_rec.free_kb;
      end
      if (q_rec.rr_ok) begin
        if (idx > rr_prev_r) begin
          if (!after_valid_r) begin
            after_valid_nxt = 1'b1;
            after_index_nxt = idx;
          end
        end else if (!wrap_valid_r) begin
          wrap_valid_nxt = 1'b1;
          wrap_index_nxt = idx;
        end
      end
      pos_nxt = pos_r + 1'b1;
    end

    if (q_pop && q_rec.last) begin
      if (select_mode == MODE_LEAST_LOAD) begin
        found  = best_valid_nxt;
        chosen = best_index_nxt;
      end else if (after_valid_nxt) begin
        found  = 1'b1;
        chosen = after_index_nxt;
      end else if (wrap_valid_nxt) begin
        found  = 1'b1;
        chosen = wrap_index_nxt;
      end
      if (select_mode == MODE_ROUND_ROBIN) begin
        if (found) begin
          rr_prev_nxt = chosen;
        end else if (rr_inc >= pos_nxt) begin
          rr_prev_nxt = '0;
        end else begin
          rr_prev_nxt = rr_inc[DIR_W-1:0];
        end
      end
      out_valid_nxt   = 1'b1;
      out_dir_nxt     = found ? chosen : '0;
      out_none_nxt    = !found;
      pos_nxt         = '0;
      best_valid_nxt  = 1'b0;
      best_index_nxt  = '0;
      best_load_nxt   = '0;
      best_unl_nxt    = 1'b1;
      best_lim_nxt    = '0;
      best_free_nxt   = '0;
      after_valid_nxt = 1'b0;
      after_index_nxt = '0;
      wrap_valid_nxt  = 1'b0;
      wrap_index_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      rr_prev_r     <= '0;
      best_valid_r  <= 1'b0;
      best_index_r  <= '0;
      best_load_r   <= '0;
      best_unl_r    <= 1'b1;
      best_lim_r    <= '0;
      best_free_r   <= '0;
      after_valid_r <= 1'b0;
      after_index_r <= '0;
      wrap_valid_r  <= 1'b0;
      wrap_index_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      pos_r         <= pos_nxt;
      rr_prev_r     <= rr_prev_nxt;
      best_valid_r  <= best_valid_nxt;
      best_index_r  <= best_index_nxt;
      best_load_r   <= best_load_nxt;
      best_unl_r    <= best_unl_nxt;
      best_lim_r    <= best_lim_nxt;
      best_free_r   <= best_free_nxt;
      after_valid_r <= after_valid_nxt;
      after_index_r <= after_index_nxt;
      wrap_valid_r  <= wrap_valid_nxt;
      wrap_index_r  <= wrap_index_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dir_r  <= out_dir_nxt;
    out_none_r <= out_none_nxt;
  end

  assign out_req.valid      = out_valid_r;
  assign out_req.chosen_dir = out_dir_r;
  assign out_req.none_found = out_none_r;

  `ASSERT_ALWAYS(a_pos_bound, clk, rst_n, pos_r <= CNT_W'(MAX_DIRS), "record count overflow")
  `ASSERT_NEXT(a_pos_clear, clk, rst_n, q_pop && q_rec.last, pos_r == '0, "request not cleared")
  `ASSERT_IMPLY(a_best_seen, clk, rst_n, best_valid_r, CNT_W'(best_index_r) < pos_r, "best index ahead of stream")
  `ASSERT_IMPLY(a_after_order, clk, rst_n, after_valid_r, after_index_r > rr_prev_r, "round-robin order broken")

endmodule

// ----- src/store_directory_selector.sv -----
// Storage directory selector.
// in_req: one request per directory record, directories in index order,
//   last_dir marks the final record of an object. One record per cycle while in_req.ready is high.
// out_req: one result per object, issued for its last record: chosen_dir,
//   or none_found = 1 when no directory qualifies.
// cfg_req: index 0 select_mode (0 least-load, 1 round-robin), index 1
//   load_limit. Always ready; write only while no object is in flight.
// Path: a taken record is classified into a two-entry queue, then the
//   back end pops it and, for the last record, the running-best update
//   loads the output register.
//   Throughput: one record per cycle while no result waits on out_req.ready,
//   limited by the single compare/update step of the back end.
// Records beyond the sixteenth are ignored for selection.
// Reset: mode least-load, load_limit 1000, round-robin pointer 0, queue
//   and partial request cleared.
// Stall: while a result waits on out_req.ready, non-final records keep
//   draining; a final record holds in the queue, which then fills and
//   drops in_req.ready.
module store_directory_selector (
  input  logic       clk,
  input  logic       rst_n,
  sds_in_if.sink     in_req,
  sds_out_if.source  out_req,
  sds_cfg_if.sink    cfg_req
);
  import sds_pkg::*;

  logic              select_mode_r;
  logic [LOAD_W-1:0] load_limit_r;
  logic              q_push, q_full, q_pop, q_head_valid;
  sds_rec_t          q_in_rec, q_head_rec;

  assign cfg_req.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      select_mode_r <= MODE_LEAST_LOAD;
      load_limit_r  <= LOAD_LIMIT_RST;
    end else if (cfg_req.valid) begin
      case (cfg_req.index)
        REG_SELECT_MODE: select_mode_r <= cfg_req.data[0];
        REG_LOAD_LIMIT:  load_limit_r  <= cfg_req.data[LOAD_W-1:0];
        default: ;
      endcase
    end
  end

  sds_front u_front (
    .q_full     (q_full),
    .load_limit (load_limit_r),
    .q_push     (q_push),
    .q_rec      (q_in_rec),
    .in_req     (in_req)
  );

  sds_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_rec   (q_in_rec),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_rec   (q_head_rec)
  );

  sds_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .select_mode (select_mode_r),
    .q_valid     (q_head_valid),
    .q_rec       (q_head_rec),
    .q_pop       (q_pop),
    .out_req     (out_req)
  );

endmodule
